### rtl/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg
// Types, character codes and token kinds shared by the markup tag tokenizer.
// ----------------------------------------------------------------------------
package mtt_pkg;

	// Lexer context, one-hot coded.
	typedef enum logic [5:0] {
		LEX_TEXT       = 6'b000001,
		LEX_TAG_START  = 6'b000010,
		LEX_TAG_NAME   = 6'b000100,
		LEX_CLOSE_SKIP = 6'b001000,
		LEX_ATTR_NAME  = 6'b010000,
		LEX_ATTR_VALUE = 6'b100000
	} ctx_t;

	localparam logic [2:0] KIND_OPEN       = 3'd0;
	localparam logic [2:0] KIND_CLOSE      = 3'd1;
	localparam logic [2:0] KIND_ATTR_NAME  = 3'd2;
	localparam logic [2:0] KIND_ATTR_VALUE = 3'd3;
	localparam logic [2:0] KIND_TEXT       = 3'd4;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;

	// One result: a token character or an end marker.
	typedef struct packed {
		logic [7:0] data;
		logic [2:0] kind;
		logic       tok_end;
	} result_t;

	// Token kind that belongs to the current context.
	function automatic logic [2:0] kind_of(ctx_t c, logic closing);
		logic [2:0] k;
		case (c)
			LEX_TAG_START, LEX_TAG_NAME, LEX_CLOSE_SKIP: k = closing ? KIND_CLOSE : KIND_OPEN;
			LEX_ATTR_NAME:  k = KIND_ATTR_NAME;
			LEX_ATTR_VALUE: k = KIND_ATTR_VALUE;
			default:        k = KIND_TEXT;
		endcase
		return k;
	endfunction

endpackage

### rtl/markup_tag_tokenizer.sv
// ----------------------------------------------------------------------------
// markup_tag_tokenizer
// Byte-serial lexer that sorts a markup document into token characters and
// token end markers of five kinds.
// ----------------------------------------------------------------------------
// Usage: the document enters one byte per input transfer on in_byte, with
// in_last set on its final byte. Each byte yields zero, one or two results
// on the output channel: a token character (token_end low, out_byte holding
// the character) or an end marker (token_end high, out_byte zero), each
// tagged with token_kind. Delimiters and newlines in text are never passed
// out, and empty tokens give no end marker.
// Latency: a result is offered in the cycle after the transfer of the byte
// that caused it, once the results ahead of it have been taken.
// Throughput: one byte per cycle while in_ready is high. Only the final byte
// of a document can yield two results, its character and the end marker of
// its token, and the output moves them out one result per transfer.
// The lexer context is updated in the cycle of the input transfer, so
// consecutive bytes follow each other with no gap.
// Results wait in a four-entry queue; in_ready is high while it holds at
// most two, so a stalled receiver holds the input back once three results
// are waiting. Reset empties the queue and returns the lexer to the text
// context, as does the byte flagged in_last after its results.
// ----------------------------------------------------------------------------
module markup_tag_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [2:0] token_kind,
	output logic       token_end
);
	import mtt_pkg::*;

	// Lexer state.
	ctx_t ctx_q;
	logic closing_q;
	logic has_q;

	// Result queue.
	result_t    queue_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] count_q;

	// Step logic.
	ctx_t       ctx_mid;
	logic       cl_mid;
	logic       has_mid;
	logic [2:0] kind_cur;
	result_t    r0;
	result_t    r1;
	logic       r0_v;
	logic       r1_v;
	result_t    slot0;
	result_t    slot1;
	logic [1:0] push_n;
	logic       in_fire;
	logic       out_fire;

	assign in_ready = (count_q < 3'd3);
	assign in_fire  = in_valid && in_ready;
	assign out_valid = (count_q != 3'd0);
	assign out_fire  = out_valid && out_ready;

	assign out_byte   = queue_q[rd_q].data;
	assign token_kind = queue_q[rd_q].kind;
	assign token_end  = queue_q[rd_q].tok_end;

	// Every result of the main step carries the kind of the context on entry;
	// only the closing marker for the end of the document sees the new one.
	always_comb begin
		ctx_mid  = ctx_q;
		cl_mid   = closing_q;
		has_mid  = has_q;
		kind_cur = kind_of(ctx_q, closing_q);
		r0       = '{data: in_byte, kind: kind_cur, tok_end: 1'b0};
		r0_v     = 1'b0;
		unique case (ctx_q)
			LEX_TAG_START: begin
				if (in_byte == CH_SLASH) begin
					cl_mid  = 1'b1;
					ctx_mid = LEX_TAG_NAME;
				end else if (in_byte == CH_GT) begin
					ctx_mid = LEX_TEXT;
				end else if (in_byte == CH_LT || in_byte == CH_SPACE ||
						in_byte == CH_EQ || in_byte == CH_QUOTE) begin
					ctx_mid = LEX_TAG_START;
				end else begin
					ctx_mid = LEX_TAG_NAME;
					r0_v    = 1'b1;
					has_mid = 1'b1;
				end
			end
			LEX_TAG_NAME: begin
				if (in_byte == CH_GT || in_byte == CH_LT || in_byte == CH_SPACE ||
						in_byte == CH_QUOTE || in_byte == CH_EQ) begin
					r0      = '{data: 8'd0, kind: kind_cur, tok_end: 1'b1};
					r0_v    = has_q;
					has_mid = 1'b0;
					if (in_byte == CH_GT) begin
						ctx_mid = LEX_TEXT;
					end else if (in_byte == CH_LT) begin
						ctx_mid = LEX_TAG_START;
						cl_mid  = 1'b0;
					end else if (closing_q) begin
						ctx_mid = LEX_CLOSE_SKIP;
					end else begin
						ctx_mid = (in_byte == CH_EQ) ? LEX_ATTR_VALUE : LEX_ATTR_NAME;
					end
				end else begin
					r0_v    = 1'b1;
					has_mid = 1'b1;
				end
			end
			LEX_CLOSE_SKIP: begin
				if (in_byte == CH_GT) begin
					ctx_mid = LEX_TEXT;
				end else if (in_byte == CH_LT) begin
					ctx_mid = LEX_TAG_START;
					cl_mid  = 1'b0;
				end
			end
			LEX_ATTR_NAME, LEX_ATTR_VALUE: begin
				// An opening quote of a value is skipped; '=' is data in a value.
				if ((ctx_q == LEX_ATTR_VALUE) && in_byte == CH_QUOTE && !has_q) begin
					ctx_mid = ctx_q;
				end else if (in_byte == CH_SPACE || in_byte == CH_QUOTE ||
						in_byte == CH_GT || in_byte == CH_LT ||
						(in_byte == CH_EQ && ctx_q == LEX_ATTR_NAME)) begin
					r0      = '{data: 8'd0, kind: kind_cur, tok_end: 1'b1};
					r0_v    = has_q;
					has_mid = 1'b0;
					if (in_byte == CH_GT) begin
						ctx_mid = LEX_TEXT;
					end else if (in_byte == CH_LT) begin
						ctx_mid = LEX_TAG_START;
						cl_mid  = 1'b0;
					end else if (in_byte == CH_EQ) begin
						ctx_mid = LEX_ATTR_VALUE;
					end else begin
						ctx_mid = LEX_ATTR_NAME;
					end
				end else begin
					r0_v    = 1'b1;
					has_mid = 1'b1;
				end
			end
			default: begin
				// Text context, and the recovery path for any illegal code.
				ctx_mid = LEX_TEXT;
				if (in_byte == CH_LT) begin
					r0      = '{data: 8'd0, kind: kind_cur, tok_end: 1'b1};
					r0_v    = has_q;
					has_mid = 1'b0;
					ctx_mid = LEX_TAG_START;
					cl_mid  = 1'b0;
				end else if (in_byte != CH_NL) begin
					r0_v    = 1'b1;
					has_mid = 1'b1;
				end
			end
		endcase

		// The final byte of a document closes any token still open.
		r1   = '{data: 8'd0, kind: kind_of(ctx_mid, cl_mid), tok_end: 1'b1};
		r1_v = in_last && has_mid;

		slot0  = r0_v ? r0 : r1;
		slot1  = r1;
		push_n = {1'b0, r0_v} + {1'b0, r1_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q     <= LEX_TEXT;
			closing_q <= 1'b0;
			has_q     <= 1'b0;
		end else if (in_fire) begin
			if (in_last) begin
				ctx_q     <= LEX_TEXT;
				closing_q <= 1'b0;
				has_q     <= 1'b0;
			end else begin
				ctx_q     <= ctx_mid;
				closing_q <= cl_mid;
				has_q     <= has_mid;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 2'd0;
			rd_q    <= 2'd0;
			count_q <= 3'd0;
		end else begin
			if (in_fire) begin
				wr_q <= wr_q + push_n;
			end
			if (out_fire) begin
				rd_q <= rd_q + 2'd1;
			end
			count_q <= count_q + (in_fire ? {1'b0, push_n} : 3'd0)
				- {2'b00, out_fire};
		end
	end

	// Queue storage holds payload only.
	always_ff @(posedge clk) begin
		if (in_fire && push_n != 2'd0) begin
			queue_q[wr_q] <= slot0;
		end
		if (in_fire && push_n == 2'd2) begin
			queue_q[wr_q + 2'd1] <= slot1;
		end
	end

	// The queue never holds more than its four entries.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue overfilled");

	// After the final byte of a document the lexer is back in text with no token.
	a_doc_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_last) |=> (ctx_q == LEX_TEXT && !closing_q && !has_q))
		else $error("lexer not reset after final byte");

	// No token is open while waiting for a tag name or skipping a close tag.
	a_no_open_token: assert property (@(posedge clk) disable iff (!arst_n)
		(ctx_q == LEX_TAG_START || ctx_q == LEX_CLOSE_SKIP) |-> !has_q)
		else $error("token open in a context that holds none");

	// Queue occupancy drops by one on an output transfer with no input transfer.
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !in_fire) |=> (count_q == $past(count_q) - 3'd1))
		else $error("queue count lost a transfer");

endmodule
